// ----- rtl/core/rpn_pkg.sv -----
// shared types and codes for the reverse polish evaluator
package rpn_pkg;

    // data word and field widths
    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 2;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    // defaults for the top level parameters
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [KIND_W-1:0]         kind_t;
    typedef logic [OP_W-1:0]           op_code_t;
    typedef logic [STATUS_W-1:0]       status_t;

    // token kinds
    localparam kind_t KIND_NUMBER   = 2'd0;
    localparam kind_t KIND_OPERATOR = 2'd1;
    localparam kind_t KIND_END      = 2'd2;

    // operator codes
    localparam op_code_t OP_ADD = 3'd0;
    localparam op_code_t OP_SUB = 3'd1;
    localparam op_code_t OP_MUL = 3'd2;
    localparam op_code_t OP_DIV = 3'd3;

    // result status codes
    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_FEW   = 3'd1;
    localparam status_t ST_DIV0  = 3'd2;
    localparam status_t ST_BADOP = 3'd3;
    localparam status_t ST_COUNT = 3'd4;
    localparam status_t ST_OVER  = 3'd5;

    // saturation limits
    localparam value_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam value_t VAL_MIN = 32'sh8000_0000;

endpackage

// ----- rtl/core/rpn_ram.sv -----
// generic single write port ram with registered read
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/rpn_div.sv -----
// unsigned restoring divider, two quotient bits per cycle
module rpn_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int QW    = NUM_W + (NUM_W % 2);
    localparam int STEPS = QW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [QW-1:0]    quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W-1:0] rem_next;
    logic [QW-1:0]    quo_next;

    // two dependent subtract steps per cycle
    always_comb begin
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] r;
        logic [QW-1:0]    q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < 2; i++) begin
            trial = {r, q[QW-1]};
            q     = {q[QW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                trial = trial - {1'b0, den_reg};
                q[0]  = 1'b1;
            end
            r = trial[DEN_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    // iteration control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= QW'(num);
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg[NUM_W-1:0];

endmodule

// ----- rtl/core/rpn_stack_evaluator.sv -----
// reverse polish evaluator top level: operand stack in ram, token sequencer, alu
//
//  channel  | ports                                                  | direction
//  ---------+--------------------------------------------------------+----------
//  tokens   | s_valid s_ready s_kind s_operand_value s_operator_code | in
//  results  | m_valid m_ready m_result_value m_status                | out
//
// a number token is one ram write, an ignored token none; add and subtract read both
// operands (S_IDLE, S_FETCH_A) and write back in S_EXEC; multiply writes back from
// S_MUL, and divide writes back from S_DIV once the two bit per cycle divider is done.
// an end token with one value held reads it in S_END and emits it; with any other count
// it goes straight to S_EMIT, and after an error it emits nothing. errors at intake go
// to S_EMIT, a zero divisor from S_EXEC; an item with a result waits for the output register.
// reset clears the count, the error flag and the handshake; stack entries are
// never read before they are written, so there is no clearing pass.
// the result register holds while m_ready is low; a new token is still taken then,
// and only an item that produces a result waits for the register to free.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH   = rpn_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rpn_pkg::kind_t    s_kind,
    input  rpn_pkg::value_t   s_operand_value,
    input  rpn_pkg::op_code_t s_operator_code,
    output logic              m_valid,
    input  logic              m_ready,
    output rpn_pkg::value_t   m_result_value,
    output rpn_pkg::status_t  m_status
);

    import rpn_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int NUM_W  = VALUE_W + FRACTION_BITS;

    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CNT_TWO    = CNT_W'(2);
    localparam logic signed [63:0] MUL_HALF  = (64'sd1 <<< FRACTION_BITS) >>> 1;
    localparam logic signed [63:0] WIDE_MAX  = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] WIDE_MIN  = -64'sh0000_0000_8000_0000;
    localparam logic [NUM_W:0]     Q_POS_LIM = (NUM_W + 1)'(64'h7FFF_FFFF);
    localparam logic [NUM_W:0]     Q_NEG_LIM = (NUM_W + 1)'(64'h8000_0000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH_A,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_END,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               error_reg;
    op_code_t           op_reg;
    value_t             b_reg;
    logic               neg_reg;
    logic signed [63:0] prod_reg;
    value_t             pend_value_reg;
    status_t            pend_status_reg;
    logic               m_valid_reg;
    value_t             m_value_reg;
    status_t            m_status_reg;

    logic               accept;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   cnt_m2;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    value_t             ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    value_t             a_val;
    logic [VALUE_W-1:0] a_abs;
    logic [VALUE_W-1:0] b_abs;
    logic signed [32:0] addsub_wide;
    value_t             addsub_sat;
    logic signed [63:0] prod_c;
    logic signed [63:0] mul_shift;
    value_t             mul_sat;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic [NUM_W:0]     quot_x;
    value_t             div_sat;
    logic               out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign cnt_m1   = count_reg - CNT_ONE;
    assign cnt_m2   = count_reg - CNT_TWO;
    assign out_free = !m_valid_reg || m_ready;

    // second operand arrives from ram in the exec cycle
    assign a_val = value_t'(ram_rdata);
    assign a_abs = a_val[VALUE_W-1] ? (32'd0 - ram_rdata) : ram_rdata;
    assign b_abs = b_reg[VALUE_W-1] ? (32'd0 - 32'(b_reg)) : 32'(b_reg);

    // add and subtract with saturation
    always_comb begin
        if (op_reg == OP_SUB) begin
            addsub_wide = {a_val[VALUE_W-1], a_val} - {b_reg[VALUE_W-1], b_reg};
        end else begin
            addsub_wide = {a_val[VALUE_W-1], a_val} + {b_reg[VALUE_W-1], b_reg};
        end
        if (addsub_wide[32] != addsub_wide[31]) begin
            addsub_sat = addsub_wide[32] ? VAL_MIN : VAL_MAX;
        end else begin
            addsub_sat = addsub_wide[31:0];
        end
    end

    // multiply: full product registered, then round, shift and saturate
    assign prod_c    = 64'(a_val) * 64'(b_reg);
    assign mul_shift = (prod_reg + MUL_HALF) >>> FRACTION_BITS;

    always_comb begin
        if (mul_shift > WIDE_MAX) begin
            mul_sat = VAL_MAX;
        end else if (mul_shift < WIDE_MIN) begin
            mul_sat = VAL_MIN;
        end else begin
            mul_sat = mul_shift[31:0];
        end
    end

    // divide on magnitudes, sign and saturation applied to the quotient
    assign div_start = (state_reg == S_EXEC) && (op_reg == OP_DIV) && (b_reg != '0);
    assign quot_x    = {1'b0, div_quot};

    always_comb begin
        if (neg_reg) begin
            div_sat = (quot_x > Q_NEG_LIM) ? VAL_MIN : value_t'(32'd0 - div_quot[31:0]);
        end else begin
            div_sat = (quot_x > Q_POS_LIM) ? VAL_MAX : value_t'(div_quot[31:0]);
        end
    end

    rpn_div #(
        .NUM_W (NUM_W),
        .DEN_W (VALUE_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (NUM_W'(a_abs) << FRACTION_BITS),
        .den     (b_abs),
        .done    (div_done),
        .quot    (div_quot)
    );

    // stack ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept && !error_reg) begin
                    if (s_kind == KIND_NUMBER && count_reg < CNT_FULL) begin
                        ram_we    = 1'b1;
                        ram_waddr = count_reg[ADDR_W-1:0];
                        ram_wdata = s_operand_value;
                    end else if (s_kind == KIND_OPERATOR && count_reg >= CNT_TWO &&
                                 s_operator_code <= OP_DIV) begin
                        ram_re    = 1'b1;
                        ram_raddr = cnt_m1[ADDR_W-1:0];
                    end else if (s_kind == KIND_END && count_reg == CNT_ONE) begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                    end
                end
            end
            S_FETCH_A: begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m2[ADDR_W-1:0];
            end
            S_EXEC: begin
                if (op_reg == OP_ADD || op_reg == OP_SUB) begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m2[ADDR_W-1:0];
                    ram_wdata = addsub_sat;
                end
            end
            S_MUL: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_m2[ADDR_W-1:0];
                ram_wdata = mul_sat;
            end
            S_DIV: begin
                if (div_done) begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m2[ADDR_W-1:0];
                    ram_wdata = div_sat;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    rpn_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // token sequencer, stack count, error flag and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            error_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // result taken by the sink, the emit state reloads it on its own
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg <= s_operator_code;
                        if (s_kind == KIND_END) begin
                            count_reg <= '0;
                            error_reg <= 1'b0;
                            if (!error_reg) begin
                                if (count_reg == CNT_ONE) begin
                                    state_reg <= S_END;
                                end else begin
                                    pend_value_reg  <= '0;
                                    pend_status_reg <= ST_COUNT;
                                    state_reg       <= S_EMIT;
                                end
                            end
                        end else if (!error_reg && s_kind == KIND_NUMBER) begin
                            if (count_reg < CNT_FULL) begin
                                count_reg <= count_reg + CNT_ONE;
                            end else begin
                                error_reg       <= 1'b1;
                                pend_value_reg  <= '0;
                                pend_status_reg <= ST_OVER;
                                state_reg       <= S_EMIT;
                            end
                        end else if (!error_reg && s_kind == KIND_OPERATOR) begin
                            if (count_reg < CNT_TWO) begin
                                error_reg       <= 1'b1;
                                pend_value_reg  <= '0;
                                pend_status_reg <= ST_FEW;
                                state_reg       <= S_EMIT;
                            end else if (s_operator_code > OP_DIV) begin
                                error_reg       <= 1'b1;
                                pend_value_reg  <= '0;
                                pend_status_reg <= ST_BADOP;
                                state_reg       <= S_EMIT;
                            end else begin
                                state_reg <= S_FETCH_A;
                            end
                        end
                    end
                end
                S_FETCH_A: begin
                    b_reg     <= value_t'(ram_rdata);
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    neg_reg  <= a_val[VALUE_W-1] ^ b_reg[VALUE_W-1];
                    prod_reg <= prod_c;
                    case (op_reg)
                        OP_ADD, OP_SUB: begin
                            count_reg <= cnt_m1;
                            state_reg <= S_IDLE;
                        end
                        OP_MUL: begin
                            state_reg <= S_MUL;
                        end
                        default: begin
                            if (b_reg == '0) begin
                                error_reg       <= 1'b1;
                                pend_value_reg  <= '0;
                                pend_status_reg <= ST_DIV0;
                                state_reg       <= S_EMIT;
                            end else begin
                                state_reg <= S_DIV;
                            end
                        end
                    endcase
                end
                S_MUL: begin
                    count_reg <= cnt_m1;
                    state_reg <= S_IDLE;
                end
                S_DIV: begin
                    if (div_done) begin
                        count_reg <= cnt_m1;
                        state_reg <= S_IDLE;
                    end
                end
                S_END: begin
                    pend_value_reg  <= value_t'(ram_rdata);
                    pend_status_reg <= ST_OK;
                    state_reg       <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_value_reg  <= pend_value_reg;
                        m_status_reg <= pend_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_status       = m_status_reg;

endmodule
